>>> hdl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared types and codes for the on-the-air bitmap decoder: result kinds,
// error codes and the per-beat result batch that passes from the parser to
// the serializer.
// ----------------------------------------------------------------------------
package otb_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } otb_kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ZERO_DIM  = 2'd1,
    ERR_BAD_DEPTH = 2'd2,
    ERR_TRUNCATED = 2'd3
  } otb_error_t;

  // The only bit depth the format allows.
  localparam logic [7:0] DEPTH_ONE = 8'h01;

  // Pixels packed into one data byte.
  localparam int unsigned PIXELS_PER_BYTE = 8;

  // Bit of the info byte that selects 16-bit dimensions.
  localparam int unsigned WIDE_DIM_BIT = 4;

  // Everything one input beat produces: up to eight results that share
  // the kind, dimensions, row, base column and packed pixel bits.
  typedef struct packed {
    logic [3:0]  count;      // number of results, 0 to 8
    otb_kind_t   kind;
    otb_error_t  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  bits;       // pixel bits, MSB first
    logic [15:0] column;     // column of the first pixel
    logic [15:0] row;
  } otb_batch_t;

  // One result as it leaves the block.
  typedef struct packed {
    otb_kind_t   kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        pixel_index;
    logic [15:0] column;
    logic [15:0] row;
    otb_error_t  error_code;
    logic        last;
  } otb_result_t;

endpackage

>>> hdl/otb_parser.sv
// ----------------------------------------------------------------------------
// otb_parser
// Header and pixel-position tracking. On each accepted beat it updates the
// stream phase, the dimensions and the row/column counters, and describes
// the results that the beat causes as one batch.
// ----------------------------------------------------------------------------
module otb_parser
  import otb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  output otb_batch_t batch
);

  typedef enum logic [2:0] {
    PH_INFO,
    PH_W_HI,
    PH_W_LO,
    PH_H_HI,
    PH_H_LO,
    PH_DEPTH,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic        header_only;
  logic        wide_dimensions, wide_dimensions_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;

  logic [15:0] remain;
  logic [15:0] height_done;
  logic [16:0] row_plus_one;

  // Next state and the batch for the current beat.
  always_comb begin
    phase_next           = phase;
    wide_dimensions_next = wide_dimensions;
    width_reg_next       = width_reg;
    height_reg_next      = height_reg;
    column_count_next    = column_count;
    row_count_next       = row_count;
    batch                = '0;
    remain               = width_reg - column_count;
    height_done          = {height_reg[15:8], data_byte};
    row_plus_one         = {1'b0, row_count} + 17'd1;

    if (end_of_data) begin
      // The stream ended; complain unless the image was already finished.
      if (phase != PH_IDLE) begin
        batch.count      = 4'd1;
        batch.kind       = KIND_ERROR;
        batch.error_code = ERR_TRUNCATED;
      end
      phase_next = PH_INFO;
    end else begin
      case (phase)
        PH_INFO: begin
          wide_dimensions_next = data_byte[WIDE_DIM_BIT];
          width_reg_next       = '0;
          height_reg_next      = '0;
          column_count_next    = '0;
          row_count_next       = '0;
          phase_next           = data_byte[WIDE_DIM_BIT] ? PH_W_HI : PH_W_LO;
        end
        PH_W_HI: begin
          width_reg_next = {data_byte, 8'h00};
          phase_next     = PH_W_LO;
        end
        PH_W_LO: begin
          width_reg_next = {width_reg[15:8], data_byte};
          phase_next     = wide_dimensions ? PH_H_HI : PH_H_LO;
        end
        PH_H_HI: begin
          height_reg_next = {data_byte, 8'h00};
          phase_next      = PH_H_LO;
        end
        PH_H_LO: begin
          height_reg_next = height_done;
          if (width_reg == '0 || height_done == '0) begin
            batch.count      = 4'd1;
            batch.kind       = KIND_ERROR;
            batch.error_code = ERR_ZERO_DIM;
            phase_next       = PH_IDLE;
          end else begin
            phase_next = PH_DEPTH;
          end
        end
        PH_DEPTH: begin
          batch.count = 4'd1;
          if (data_byte != DEPTH_ONE) begin
            batch.kind       = KIND_ERROR;
            batch.error_code = ERR_BAD_DEPTH;
            phase_next       = PH_IDLE;
          end else begin
            batch.kind         = KIND_HEADER;
            batch.image_width  = width_reg;
            batch.image_height = height_reg;
            column_count_next  = '0;
            row_count_next     = '0;
            phase_next         = header_only ? PH_IDLE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          // Up to eight pixels; the rest of the byte past the row end is padding.
          batch.kind   = KIND_PIXEL;
          batch.bits   = data_byte;
          batch.column = column_count;
          batch.row    = row_count;
          if (remain < 16'(PIXELS_PER_BYTE)) begin
            batch.count = remain[3:0];
          end else begin
            batch.count = 4'(PIXELS_PER_BYTE);
          end
          if (remain <= 16'(PIXELS_PER_BYTE)) begin
            column_count_next = '0;
            if (row_plus_one >= {1'b0, height_reg}) begin
              row_count_next = '0;
              phase_next     = PH_IDLE;
            end else begin
              row_count_next = row_plus_one[15:0];
            end
          end else begin
            column_count_next = column_count + 16'(PIXELS_PER_BYTE);
          end
        end
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_INFO;
      header_only     <= 1'b0;
      wide_dimensions <= 1'b0;
      width_reg       <= '0;
      height_reg      <= '0;
      column_count    <= '0;
      row_count       <= '0;
    end else begin
      if (cfg_we) begin
        header_only <= cfg_wdata;
      end
      if (accept) begin
        phase           <= phase_next;
        wide_dimensions <= wide_dimensions_next;
        width_reg       <= width_reg_next;
        height_reg      <= height_reg_next;
        column_count    <= column_count_next;
        row_count       <= row_count_next;
      end
    end
  end

endmodule

>>> hdl/otb_serializer.sv
// ----------------------------------------------------------------------------
// otb_serializer
// Holds one result batch and sends its results one per cycle, while the output
// is not stalled, through a registered output stage. A new batch loads in the
// cycle the previous one hands over its last result.
// ----------------------------------------------------------------------------
module otb_serializer
  import otb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  otb_batch_t  batch_in,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_stall,
  output otb_result_t result
);

  otb_batch_t  batch;
  logic        batch_valid;
  logic [2:0]  idx;
  logic        cur_last;
  logic        out_load;
  logic [7:0]  shifted;
  otb_result_t cur;

  // Result at the current position of the held batch.
  always_comb begin
    shifted  = batch.bits << idx;
    cur_last = ({1'b0, idx} + 4'd1) == batch.count;
    cur      = '0;
    cur.kind = batch.kind;
    cur.last = cur_last;
    case (batch.kind)
      KIND_HEADER: begin
        cur.image_width  = batch.image_width;
        cur.image_height = batch.image_height;
      end
      KIND_PIXEL: begin
        cur.pixel_index = ~shifted[7];
        cur.column      = batch.column + 16'(idx);
        cur.row         = batch.row;
      end
      KIND_ERROR: begin
        cur.error_code = batch.error_code;
      end
      default: begin
        cur.error_code = batch.error_code;
      end
    endcase
  end

  // Output register takes a result when it is empty or being drained.
  assign out_load = batch_valid && (!out_valid || !out_stall);
  assign busy     = batch_valid && !(out_load && cur_last);

  // Batch holding stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_valid <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        result    <= cur;
        if (cur_last) begin
          batch_valid <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take && batch_in.count != '0) begin
        batch       <= batch_in;
        batch_valid <= 1'b1;
        idx         <= '0;
      end
    end
  end

  // A held batch always has results left to send.
  a_batch_nonempty: assert property (@(posedge clk) disable iff (rst)
    batch_valid |-> ({1'b0, idx} < batch.count))
    else $error("held batch has no result left");

  // A batch never carries more results than a byte has pixels.
  a_batch_count: assert property (@(posedge clk) disable iff (rst)
    batch_valid |-> (batch.count <= 4'(PIXELS_PER_BYTE)))
    else $error("batch count above pixels per byte");

  // Header and error results are always the only result of their beat.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind != KIND_PIXEL |-> result.last)
    else $error("header or error result without last");

  // While a batch is still sending, no new beat is taken.
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    batch_valid && !(out_load && cur_last) |-> busy)
    else $error("input taken over an unfinished batch");

endmodule

>>> hdl/otb_bitmap_decoder_core.sv
// ----------------------------------------------------------------------------
// otb_bitmap_decoder_core
// On-the-air bitmap stream decoder: parses the header and expands each
// image byte into pixel results.
// ----------------------------------------------------------------------------
// A stream beat is taken when the block is not busy. Header bytes, idle bytes
// and a beat that ends the stream produce at most one result each; an image
// byte produces one pixel result per cycle while the output is not stalled,
// one for each pixel it holds (eight, fewer at a row end), and holds off the
// next beat until they are sent from the result register. The next beat is
// taken in the same cycle as the last result of the previous one. Pixels
// come MSB first, index 0 for a set bit, with row and column attached. The
// header_only bit stops decoding after the header result; the user must write
// it through cfg_we and cfg_wdata only while the block is idle (not enforced).
module otb_bitmap_decoder_core
  import otb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        pixel_index,
  output logic [15:0] column,
  output logic [15:0] row,
  output logic [1:0]  error_code,
  output logic        last
);

  logic        accept;
  otb_batch_t  batch;
  otb_result_t result;

  // A beat is accepted when the batch stage can take it.
  assign accept = in_valid && !in_stall;

  // Header parsing and position tracking.
  otb_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .batch       (batch)
  );

  // One result per cycle to the output while it is not stalled.
  otb_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .batch_in  (batch),
    .busy      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  // Result fields onto the ports.
  assign kind         = result.kind;
  assign image_width  = result.image_width;
  assign image_height = result.image_height;
  assign pixel_index  = result.pixel_index;
  assign column       = result.column;
  assign row          = result.row;
  assign error_code   = result.error_code;
  assign last         = result.last;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the on-the-air bitmap decoder. A directed opening
// covers header extremes, row padding, trailing bytes and each header error.
// Random streams follow, mostly well-formed images with random pixel content
// and the rest truncated, malformed or noise. The bench runs them under
// several idle and stall patterns and with header_only both clear and set. A
// scoreboard mirrors the parser state and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import otb_pkg::*;

  // Parser states mirrored by the scoreboard.
  typedef enum logic [2:0] {
    ST_INFO, ST_W_HI, ST_W_LO, ST_H_HI, ST_H_LO, ST_DEPTH, ST_PIXELS, ST_IDLE
  } parse_state_t;

  // Mirrors the decoder state, predicts results per input beat and checks them.
  class bitmap_scoreboard;
    bit           header_only;
    parse_state_t state;
    bit           wide;
    logic [15:0]  width_q;
    logic [15:0]  height_q;
    logic [15:0]  col_q;
    logic [15:0]  row_q;
    otb_result_t  awaited_results[$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    function new();
      header_only = 1'b0;
      state = ST_INFO;
      wide = 1'b0;
      width_q = '0;
      height_q = '0;
      col_q = '0;
      row_q = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_header_only(bit v);
      header_only = v;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function void queue_result(otb_kind_t k, logic [15:0] w, logic [15:0] h,
                               logic pix, logic [15:0] col, logic [15:0] rw,
                               otb_error_t err, logic lst);
      otb_result_t r;
      r.kind = k;
      r.image_width = w;
      r.image_height = h;
      r.pixel_index = pix;
      r.column = col;
      r.row = rw;
      r.error_code = err;
      r.last = lst;
      awaited_results.push_back(r);
    endfunction

    // Advances the mirrored parser by one accepted beat.
    function void decode_beat(logic [7:0] b, logic eod);
      int unsigned remain;
      int unsigned cnt;
      if (eod) begin
        if (state != ST_IDLE)
          queue_result(KIND_ERROR, '0, '0, 1'b0, '0, '0, ERR_TRUNCATED, 1'b1);
        state = ST_INFO;
        return;
      end
      case (state)
        ST_INFO: begin
          wide = b[WIDE_DIM_BIT];
          width_q = '0;
          height_q = '0;
          col_q = '0;
          row_q = '0;
          state = wide ? ST_W_HI : ST_W_LO;
        end
        ST_W_HI: begin
          width_q = {b, 8'h00};
          state = ST_W_LO;
        end
        ST_W_LO: begin
          width_q[7:0] = b;
          state = wide ? ST_H_HI : ST_H_LO;
        end
        ST_H_HI: begin
          height_q = {b, 8'h00};
          state = ST_H_LO;
        end
        ST_H_LO: begin
          height_q[7:0] = b;
          if (width_q == '0 || height_q == '0) begin
            queue_result(KIND_ERROR, '0, '0, 1'b0, '0, '0, ERR_ZERO_DIM, 1'b1);
            state = ST_IDLE;
          end else begin
            state = ST_DEPTH;
          end
        end
        ST_DEPTH: begin
          if (b != DEPTH_ONE) begin
            queue_result(KIND_ERROR, '0, '0, 1'b0, '0, '0, ERR_BAD_DEPTH, 1'b1);
            state = ST_IDLE;
          end else begin
            queue_result(KIND_HEADER, width_q, height_q, 1'b0, '0, '0, ERR_NONE,
                         1'b1);
            col_q = '0;
            row_q = '0;
            state = header_only ? ST_IDLE : ST_PIXELS;
          end
        end
        ST_PIXELS: begin
          // Bits past the end of the row are padding and produce nothing.
          remain = 32'(width_q) - 32'(col_q);
          cnt = (remain < PIXELS_PER_BYTE) ? remain : PIXELS_PER_BYTE;
          for (int i = 0; i < cnt; i++)
            queue_result(KIND_PIXEL, '0, '0, ~b[7 - i], col_q + 16'(i), row_q,
                         ERR_NONE, i == cnt - 1);
          col_q = col_q + 16'(cnt);
          if (col_q >= width_q) begin
            col_q = '0;
            if (int'(row_q) + 1 >= int'(height_q)) begin
              row_q = '0;
              state = ST_IDLE;
            end else begin
              row_q = row_q + 1'b1;
            end
          end
        end
        default: state = ST_IDLE;
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch at %0t, result %0d: %s", $time, results_seen, msg);
    endtask

    task field_check(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compares one accepted result beat with the oldest prediction.
    task check_result(otb_result_t got);
      otb_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result of kind %0d with nothing predicted", got.kind));
        return;
      end
      want = awaited_results.pop_front();
      field_check("kind", 16'(got.kind), 16'(want.kind));
      field_check("image_width", got.image_width, want.image_width);
      field_check("image_height", got.image_height, want.image_height);
      field_check("pixel_index", 16'(got.pixel_index), 16'(want.pixel_index));
      field_check("column", got.column, want.column);
      field_check("row", got.row, want.row);
      field_check("error_code", 16'(got.error_code), 16'(want.error_code));
      field_check("last", 16'(got.last), 16'(want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        pixel_index;
  logic [15:0] column;
  logic [15:0] row;
  logic [1:0]  error_code;
  logic        last;

  bitmap_scoreboard sb = new();
  otb_result_t      seen_result;

  // Beats of the stream being sent: {eod, byte}.
  logic [8:0]  stream_q[$];
  int unsigned sent_beats;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  otb_bitmap_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_data  (end_of_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .image_width  (image_width),
    .image_height (image_height),
    .pixel_index  (pixel_index),
    .column       (column),
    .row          (row),
    .error_code   (error_code),
    .last         (last)
  );

  always #2 clk = ~clk;

  // Receiver side: random stall, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both channels are observed at the rising edge; inputs are noted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.decode_beat(data_byte, end_of_data);
      if (out_valid && !out_stall) begin
        seen_result.kind = otb_kind_t'(kind);
        seen_result.image_width = image_width;
        seen_result.image_height = image_height;
        seen_result.pixel_index = pixel_index;
        seen_result.column = column;
        seen_result.row = row;
        seen_result.error_code = otb_error_t'(error_code);
        seen_result.last = last;
        sb.check_result(seen_result);
      end
    end
  end

  // Presents one beat, with an optional random gap first, and waits until
  // it is taken. Returns on the falling edge after acceptance.
  task automatic send_beat(input logic [7:0] b, input logic eod);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) begin
      send_beat(stream_q[i][7:0], stream_q[i][8]);
      sent_beats++;
    end
  endtask

  function automatic void push_beat(logic [7:0] b, bit eod);
    stream_q.push_back({eod, b});
  endfunction

  // Info byte with random spare bits, dimensions, then the depth byte.
  function automatic void push_header(bit wide, logic [15:0] w, logic [15:0] h,
                                      logic [7:0] depth);
    logic [7:0] info;
    info = 8'($urandom);
    info[WIDE_DIM_BIT] = wide;
    push_beat(info, 1'b0);
    if (wide)
      push_beat(w[15:8], 1'b0);
    push_beat(w[7:0], 1'b0);
    if (wide)
      push_beat(h[15:8], 1'b0);
    push_beat(h[7:0], 1'b0);
    push_beat(depth, 1'b0);
  endfunction

  function automatic void push_pixel_bytes(int unsigned w, int unsigned h,
                                           int unsigned limit);
    int unsigned n;
    n = ((w + 7) / 8) * h;
    if (n > limit)
      n = limit;
    repeat (n) push_beat(8'($urandom), 1'b0);
  endfunction

  // Builds one random stream, always closed by an end-of-data beat.
  task automatic build_random_stream();
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int unsigned dim_max;
    int unsigned cut;
    bit          wide;
    logic [7:0]  depth;
    stream_q.delete();
    pick = $urandom_range(99);
    wide = 1'($urandom_range(1));
    dim_max = wide ? 65535 : 255;
    if (pick < 60) begin
      // Complete image, then a few bytes the decoder must ignore.
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 5);
      push_header(wide, 16'(w), 16'(h), DEPTH_ONE);
      push_pixel_bytes(w, h, 15);
      repeat ($urandom_range(2)) push_beat(8'($urandom), 1'b0);
    end else if (pick < 75) begin
      // Stream cut anywhere, from empty to a few pixel bytes in.
      w = $urandom_range(1, dim_max);
      h = $urandom_range(1, dim_max);
      push_header(wide, 16'(w), 16'(h), DEPTH_ONE);
      push_pixel_bytes(w, h, 4);
      cut = $urandom_range(stream_q.size());
      while (stream_q.size() > cut)
        void'(stream_q.pop_back());
    end else if (pick < 85) begin
      // Zero width, zero height or both; the depth byte is then ignored.
      case ($urandom_range(2))
        0: begin
          w = 0;
          h = $urandom_range(1, dim_max);
        end
        1: begin
          w = $urandom_range(1, dim_max);
          h = 0;
        end
        default: begin
          w = 0;
          h = 0;
        end
      endcase
      push_header(wide, 16'(w), 16'(h), DEPTH_ONE);
      repeat ($urandom_range(2)) push_beat(8'($urandom), 1'b0);
    end else if (pick < 93) begin
      // Depth other than one.
      depth = 8'($urandom_range(255));
      if (depth == DEPTH_ONE)
        depth = 8'h00;
      push_header(wide, 16'($urandom_range(1, 20)), 16'($urandom_range(1, 5)),
                  depth);
      repeat ($urandom_range(2)) push_beat(8'($urandom), 1'b0);
    end else begin
      // Plain noise.
      repeat ($urandom_range(1, 6)) push_beat(8'($urandom), 1'b0);
    end
    push_beat(8'($urandom), 1'b1);
  endtask

  task automatic write_header_only(input bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_header_only(v);
  endtask

  // Drains every predicted result, then lets a trailing beat settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned send_p, input int unsigned stall_p,
                           input bit ho);
    wait_idle();
    write_header_only(ho);
    send_idle_pct = send_p;
    stall_pct = stall_p;
    sent_beats = 0;
    while (sent_beats < 45) begin
      build_random_stream();
      send_stream();
    end
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    data_byte = 8'h00;
    end_of_data = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    write_header_only(1'b0);

    stream_q.delete();
    // Empty stream.
    push_beat(8'h00, 1'b1);
    // Narrow 3x2 image with row padding, a trailing byte, then end of data.
    push_beat(8'hEF, 1'b0);
    push_beat(8'd3, 1'b0);
    push_beat(8'd2, 1'b0);
    push_beat(DEPTH_ONE, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h5A, 1'b0);
    push_beat(8'h55, 1'b0);
    push_beat(8'h00, 1'b1);
    // Widest header, one pixel byte, then truncation.
    push_beat(8'h10, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(DEPTH_ONE, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'hFF, 1'b1);
    // Zero width.
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h05, 1'b0);
    push_beat(8'h00, 1'b1);
    // Bad depth.
    push_beat(8'h00, 1'b0);
    push_beat(8'd3, 1'b0);
    push_beat(8'd1, 1'b0);
    push_beat(8'hFE, 1'b0);
    push_beat(8'h00, 1'b1);
    send_stream();

    run_phase(68, 0, 1'b1);
    run_phase(0, 68, 1'b0);
    run_phase(37, 37, 1'b1);
    run_phase(0, 0, 1'b0);
    wait_idle();

    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
